// File: src/audio_sample_pacer_macros.svh
// ----------------------------------------------------------------------------
// Audio sample pacer assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_SAMPLE_PACER_MACROS_SVH
`define AUDIO_SAMPLE_PACER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define ASP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("audio_sample_pacer: same-cycle check failed");

// Check a consequent in the cycle after its antecedent
`define ASP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("audio_sample_pacer: next-cycle check failed");

`endif

// File: src/asp_pkg.sv
// ----------------------------------------------------------------------------
// Audio sample pacer package
// Constants, payload types and divider interface types of the pacer.
// ----------------------------------------------------------------------------
package asp_pkg;

    // Pacing constants
    localparam int CYCLES_PER_SAMPLE = 64;
    localparam int FRAME_PAIRS       = 640;
    localparam int RATE_BASE         = 32000;

    // Field widths
    localparam int CYCLE_W = 32;
    localparam int CPS_W   = $clog2(CYCLES_PER_SAMPLE);
    localparam int QUOT_W  = CYCLE_W - CPS_W;
    localparam int PAIR_W  = 10;
    localparam int TOTAL_W = PAIR_W + 1;
    localparam int BAL_W   = 25;
    localparam int DEN_W   = 16;
    localparam int DIV_W   = (QUOT_W > BAL_W) ? QUOT_W : BAL_W;
    localparam int DCNT_W  = $clog2(DIV_W);

    // Rate ratios
    localparam logic [BAL_W-1:0] PAL_NUM  = BAL_W'(RATE_BASE);
    localparam logic [DEN_W-1:0] PAL_DEN  = DEN_W'(50);
    localparam logic [BAL_W-1:0] NTSC_NUM = BAL_W'(995 * RATE_BASE);
    localparam logic [DEN_W-1:0] NTSC_DEN = DEN_W'(59649);

    localparam logic [PAIR_W-1:0] FRAME_PAIRS_V = PAIR_W'(FRAME_PAIRS);

    // Input commands
    typedef enum logic {
        CMD_MID_FRAME = 1'b0,
        CMD_END_FRAME = 1'b1
    } asp_cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } asp_state_t;

    // Channel payloads
    typedef struct packed {
        logic               command;
        logic [CYCLE_W-1:0] cycle_count;
    } asp_in_item_t;

    typedef struct packed {
        logic [PAIR_W-1:0]  run_samples;
        logic [PAIR_W-1:0]  buffer_offset;
        logic [TOTAL_W-1:0] frame_sample_count;
    } asp_out_item_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } asp_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } asp_div_rsp_t;

endpackage

// File: src/audio_sample_pacer.sv
// ----------------------------------------------------------------------------
// Audio sample pacer
// Converts CPU cycle counter advances to stereo samples against a per-frame quota and draws
// each next quota from a fractional rate accumulator.
// ----------------------------------------------------------------------------
//  Channel   Signals                      Transfer when
//  input     in_valid, in_stall, in_data  in_valid && !in_stall
//  output    out_valid, out_stall, out_data out_valid && !out_stall
//  config    cfg_wr_en, cfg_wr_data       cfg_wr_en
//
//  One item at a time. An end-of-frame item, or a mid-frame item with a
//  nonzero quota and at least one whole sample, runs the shared 26-bit
//  restoring divider (one bit per cycle); other mid-frame items skip it.
//  No clearing pass after reset. A stalled output holds its result; the
//  sequencer waits in its final step until the output register is free.
// ----------------------------------------------------------------------------
module audio_sample_pacer
    import asp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  asp_in_item_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output asp_out_item_t out_data,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data
);

    asp_state_t state_reg;
    asp_state_t state_next;

    // Pacing state
    logic               pal_mode_reg;
    logic [CPS_W-1:0]   cyc_rem_reg;
    logic [CYCLE_W-1:0] prev_cycle_reg;
    logic [PAIR_W-1:0]  done_reg;
    logic [PAIR_W-1:0]  quota_reg;
    logic [BAL_W-1:0]   balance_reg;
    logic               use_div_reg;
    logic               out_valid_reg;

    // Latched item
    logic               cmd_reg;
    logic [CYCLE_W-1:0] cycle_reg;
    asp_out_item_t      out_data_reg;

    // Sequencer outputs
    logic in_take;
    logic do_prep;
    logic do_finish;
    logic out_free;

    asp_div_req_t div_req;
    asp_div_rsp_t div_rsp;

    // Datapath helpers
    logic [CYCLE_W-1:0] diff;
    logic [QUOT_W-1:0]  quot;
    logic               mid_div;
    logic [BAL_W-1:0]   cur_num;
    logic [DEN_W-1:0]   cur_den;
    logic [PAIR_W-1:0]  left;
    logic [PAIR_W:0]    raw_samples;
    logic [PAIR_W-1:0]  run_mid;
    logic [PAIR_W-1:0]  new_quota;
    asp_out_item_t      result;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_PREP;
            ST_PREP:   state_next = div_req.start ? ST_DIV : ST_FINISH;
            ST_DIV:    if (div_rsp.done) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        in_take   = 1'b0;
        do_prep   = 1'b0;
        do_finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                in_take  = in_valid;
            end
            ST_PREP:   do_prep = 1'b1;
            ST_DIV:    do_finish = 1'b0;
            ST_FINISH: do_finish = out_free;
            default:   in_stall = 1'b1;
        endcase
    end

    // Cycle conversion and divider operands
    always_comb
    begin
        diff    = cycle_reg - prev_cycle_reg + CYCLE_W'(cyc_rem_reg);
        quot    = diff[CYCLE_W-1:CPS_W];
        mid_div = (quota_reg != '0) && (quot != '0);
        cur_num = pal_mode_reg ? PAL_NUM : NTSC_NUM;
        cur_den = pal_mode_reg ? PAL_DEN : NTSC_DEN;

        div_req.start = do_prep && ((cmd_reg == CMD_END_FRAME) || mid_div);
        if (cmd_reg == CMD_END_FRAME)
        begin
            div_req.dividend = DIV_W'(balance_reg);
            div_req.divisor  = cur_den;
        end
        else
        begin
            div_req.dividend = DIV_W'(quot - 1'b1);
            div_req.divisor  = DEN_W'(quota_reg);
        end
    end

    // Clamp the sample count and build the result
    always_comb
    begin
        left        = quota_reg - done_reg;
        raw_samples = use_div_reg ? ({1'b0, div_rsp.remainder[PAIR_W-1:0]} + 1'b1) : '0;
        if (done_reg >= quota_reg)
            run_mid = '0;
        else if (raw_samples > {1'b0, left})
            run_mid = left;
        else
            run_mid = raw_samples[PAIR_W-1:0];

        if (div_rsp.quotient > DIV_W'(FRAME_PAIRS))
            new_quota = FRAME_PAIRS_V;
        else
            new_quota = div_rsp.quotient[PAIR_W-1:0];

        result = '0;
        if (cmd_reg == CMD_END_FRAME)
        begin
            if (quota_reg > done_reg)
            begin
                result.run_samples   = left;
                result.buffer_offset = done_reg;
            end
            result.frame_sample_count = {quota_reg, 1'b0};
        end
        else if (run_mid != '0)
        begin
            result.run_samples   = run_mid;
            result.buffer_offset = done_reg;
        end
    end

    // State register, pacing state, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pal_mode_reg   <= 1'b0;
            cyc_rem_reg    <= '0;
            prev_cycle_reg <= '0;
            done_reg       <= '0;
            quota_reg      <= '0;
            balance_reg    <= NTSC_NUM;
            use_div_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop the result once taken, load a new one on finish
            if (do_finish)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_wr_en)
            begin
                // Reload the pacing state for the chosen mode
                pal_mode_reg   <= cfg_wr_data;
                cyc_rem_reg    <= '0;
                prev_cycle_reg <= '0;
                done_reg       <= '0;
                quota_reg      <= '0;
                balance_reg    <= cfg_wr_data ? PAL_NUM : NTSC_NUM;
            end
            else
            begin
                if (do_prep)
                begin
                    use_div_reg <= div_req.start;
                    if (cmd_reg == CMD_MID_FRAME)
                    begin
                        cyc_rem_reg    <= diff[CPS_W-1:0];
                        prev_cycle_reg <= cycle_reg;
                    end
                end
                if (do_finish)
                begin
                    if (cmd_reg == CMD_END_FRAME)
                    begin
                        done_reg    <= '0;
                        quota_reg   <= new_quota;
                        balance_reg <= BAL_W'(div_rsp.remainder) + cur_num;
                    end
                    else
                    begin
                        done_reg <= done_reg + run_mid;
                    end
                end
            end
        end
    end

    // Hold the accepted item and the finished result
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= in_data.command;
            cycle_reg <= in_data.cycle_count;
        end
        if (do_finish)
            out_data_reg <= result;
    end

    asp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: src/asp_div.sv
// ----------------------------------------------------------------------------
// Audio sample pacer divider
// Restoring divider, one quotient bit per cycle, shared by both commands.
// ----------------------------------------------------------------------------
module asp_div
    import asp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  asp_div_req_t req,
    output asp_div_rsp_t rsp
);

    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    trial;
    logic              fits;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], fits};
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: src/asp_checker.sv
// ----------------------------------------------------------------------------
// Audio sample pacer checker
// Port-level checks on the pacer's handshake and result fields.
// ----------------------------------------------------------------------------
`include "audio_sample_pacer_macros.svh"

module asp_checker
    import asp_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input asp_out_item_t out_data
);

    logic [TOTAL_W-1:0] span_end;
    logic               no_run;

    // End of the span touched by the result (one past its last pair), and the empty-run flag
    assign span_end = TOTAL_W'(out_data.buffer_offset) + TOTAL_W'(out_data.run_samples);
    assign no_run   = (out_data.run_samples == '0);

    // Busy right after a transfer in
    `ASP_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)

    // Hold a stalled result
    `ASP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

    // Samples stay within the frame buffer
    `ASP_ASSERT_IMP(a_in_frame, out_valid, span_end <= TOTAL_W'(FRAME_PAIRS))

    // No offset without samples
    `ASP_ASSERT_IMP(a_offset_zero, out_valid && no_run, out_data.buffer_offset == '0)

    // Frame totals count whole stereo pairs
    `ASP_ASSERT_IMP(a_total_even, out_valid, !out_data.frame_sample_count[0])

endmodule

bind audio_sample_pacer asp_checker u_asp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Audio sample pacer testbench
// Drives mid-frame and end-of-frame transfers with random gaps and output
// stalls, predicts each result from a local model of the cycle-to-sample
// conversion and the fractional quota accumulator, and checks every result
// field by field. Covers both rate modes, including a repeated mode write.
// ----------------------------------------------------------------------------
module tb;
    import asp_pkg::*;

    // Pacing arithmetic, kept apart from the block's own constants
    localparam int unsigned      SAMPLE_CYCLES = 64;
    localparam int unsigned      PAIR_LIMIT    = 640;
    localparam longint unsigned  PAL_RATE_NUM  = 64'd32000;
    localparam longint unsigned  PAL_RATE_DEN  = 64'd50;
    localparam longint unsigned  NTSC_RATE_NUM = 64'd995 * 64'd32000;
    localparam longint unsigned  NTSC_RATE_DEN = 64'd59649;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 500;
    localparam int IDLE_LIMIT    = 2000;
    localparam int REPORT_LIMIT  = 10;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          in_valid    = 1'b0;
    logic          in_stall;
    asp_in_item_t  in_data     = '0;
    logic          out_valid;
    logic          out_stall   = 1'b0;
    asp_out_item_t out_data;
    logic          cfg_wr_en   = 1'b0;
    logic          cfg_wr_data = 1'b0;

    // Predictor state
    bit              pal_sel;
    int unsigned     rem_cycles;
    int unsigned     last_count;
    int unsigned     pairs_done;
    int unsigned     quota;
    longint unsigned balance;

    asp_in_item_t  pending_items[$];
    asp_out_item_t due_results[$];
    int unsigned   cpu_cycles;
    int            faults;
    int            in_gap;
    int            in_calm;
    int            out_left;
    int            out_calm;
    int            idle_cycles;

    audio_sample_pacer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    // Return the pacer to its post-reset state under the given rate mode
    function automatic void restart_pacing(bit pal);
        pal_sel    = pal;
        rem_cycles = 0;
        last_count = 0;
        pairs_done = 0;
        quota      = 0;
        balance    = pal ? PAL_RATE_NUM : NTSC_RATE_NUM;
    endfunction

    // Advance the pacing state by one item and return the result it yields
    function automatic asp_out_item_t pace_item(asp_in_item_t item);
        asp_out_item_t   r;
        int unsigned     span;
        int unsigned     whole;
        int unsigned     grant;
        longint unsigned den;
        longint unsigned next_quota;
        r   = '0;
        den = pal_sel ? PAL_RATE_DEN : NTSC_RATE_DEN;
        if (asp_cmd_t'(item.command) == CMD_MID_FRAME) begin
            span       = rem_cycles + item.cycle_count - last_count;
            whole      = span / SAMPLE_CYCLES;
            rem_cycles = span % SAMPLE_CYCLES;
            grant      = 0;
            // Fold a large catch-up back into the quota
            if (quota != 0 && whole != 0)
                grant = ((whole - 1) % quota) + 1;
            // Clamp to what is left of the frame
            if (pairs_done >= quota)
                grant = 0;
            else if (grant > quota - pairs_done)
                grant = quota - pairs_done;
            if (grant != 0) begin
                r.run_samples   = grant[PAIR_W-1:0];
                r.buffer_offset = pairs_done[PAIR_W-1:0];
                pairs_done      = pairs_done + grant;
            end
            last_count = item.cycle_count;
        end else begin
            // Flush the rest of the frame and report its size in words
            if (quota > pairs_done) begin
                r.run_samples   = PAIR_W'(quota - pairs_done);
                r.buffer_offset = pairs_done[PAIR_W-1:0];
            end
            r.frame_sample_count = TOTAL_W'(quota * 2);
            pairs_done = 0;
            // Draw the next quota from the rate accumulator
            next_quota = balance / den;
            if (next_quota > PAIR_LIMIT)
                next_quota = PAIR_LIMIT;
            quota   = int'(next_quota);
            balance = balance % den + (pal_sel ? PAL_RATE_NUM : NTSC_RATE_NUM);
        end
        return r;
    endfunction

    // Pick a per-item wait, with occasional runs of back-to-back transfers
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    task automatic report_fault(string what, asp_out_item_t want, asp_out_item_t got);
        faults++;
        if (faults <= REPORT_LIMIT)
            $display("mismatch (%s): expected run=%0d off=%0d total=%0d, got run=%0d off=%0d total=%0d",
                     what, want.run_samples, want.buffer_offset, want.frame_sample_count,
                     got.run_samples, got.buffer_offset, got.frame_sample_count);
    endtask

    task automatic push_mid(int unsigned count);
        asp_in_item_t item;
        item.command     = CMD_MID_FRAME;
        item.cycle_count = count;
        pending_items.push_back(item);
        cpu_cycles = count;
    endtask

    task automatic push_end(int unsigned count);
        asp_in_item_t item;
        item.command     = CMD_END_FRAME;
        item.cycle_count = count;
        pending_items.push_back(item);
    endtask

    // Queue random frames: mostly steady cycle advances, some wraps and jumps
    task automatic queue_frames(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                push_end($urandom);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    push_mid(cpu_cycles + $urandom_range(0, 12000));
                else if (pick < 75)
                    push_mid(cpu_cycles + $urandom_range(0, SAMPLE_CYCLES - 1));
                else if (pick < 85)
                    push_mid(cpu_cycles + $urandom_range(30000, 40000));
                else if (pick < 92)
                    push_mid(cpu_cycles + $urandom);
                else
                    push_mid($urandom);
            end
        end
    endtask

    // Wait for every queued item to be answered, then let the block go idle;
    // sample on the falling edge so the driver's updates have settled
    task automatic drain();
        asp_out_item_t lost;
        while (pending_items.size() != 0 || in_valid)
            @(negedge clk);
        for (int n = 0; n < DRAIN_LIMIT && due_results.size() != 0; n++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (due_results.size() != 0) begin
            lost = due_results.pop_front();
            report_fault("missing result", lost, '0);
        end
    endtask

    task automatic write_mode(bit pal);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pal;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        restart_pacing(pal);
    endtask

    // Input driver: present queued items, hold while stalled
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end else begin
            if (in_valid && !in_stall)
                due_results.push_back(pace_item(in_data));
            if (in_valid && in_stall) begin
                // hold the stalled transfer
            end else if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (pending_items.size() != 0) begin
                in_valid <= 1'b1;
                in_data  <= pending_items.pop_front();
                in_gap   <= draw_wait(in_calm);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each transfer, then stall for a drawn while
    always @(posedge clk or negedge rst_n) begin : monitor
        asp_out_item_t want;
        int            next_left;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_left  <= 0;
        end else begin
            next_left = out_left;
            if (out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    report_fault("unexpected result", '0, out_data);
                end else begin
                    want = due_results.pop_front();
                    if (out_data.run_samples !== want.run_samples
                            || out_data.buffer_offset !== want.buffer_offset
                            || out_data.frame_sample_count !== want.frame_sample_count)
                        report_fault("field", want, out_data);
                end
                next_left = draw_wait(out_calm);
            end
            if (next_left > 0) begin
                out_stall <= 1'b1;
                out_left  <= next_left - 1;
            end else begin
                out_stall <= 1'b0;
                out_left  <= 0;
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** audio_sample_pacer: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin
        faults     = 0;
        cpu_cycles = 0;
        in_calm    = 0;
        out_calm   = 0;
        restart_pacing(1'b0);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero quota: nothing runs before the first frame ends
        push_mid(32'd0);
        push_mid(32'hFFFF_FFFF);
        // First end of frame reports an empty frame and draws a quota
        push_end(32'hFFFF_FFFF);
        // Cycle counter wraps past zero
        push_mid(32'd0);
        push_mid(cpu_cycles + 100 * SAMPLE_CYCLES);
        push_mid(cpu_cycles + SAMPLE_CYCLES - 1);
        // Large catch-up folds into the quota, then the frame is full
        push_mid(cpu_cycles + 5000 * SAMPLE_CYCLES);
        push_mid(cpu_cycles + 300 * SAMPLE_CYCLES);
        push_end(32'd0);
        push_mid(cpu_cycles + 10 * SAMPLE_CYCLES);
        push_end(32'h5555_5555);
        // Back-to-back frame ends flush whole quotas
        push_end(32'hAAAA_AAAA);
        push_end(32'd0);
        // Exact multiple of the quota
        push_mid(cpu_cycles + 1066 * SAMPLE_CYCLES);
        push_end(32'd0);
        push_mid(32'h8000_0000);
        push_mid(32'h7FFF_FFFF);
        push_mid(32'hFFFF_FFFF);
        push_end(32'hFFFF_FFFF);
        push_mid(32'd1);
        queue_frames(400);
        drain();

        write_mode(1'b1);
        cpu_cycles = 0;
        push_mid(32'd0);
        push_end(32'd0);
        push_mid(cpu_cycles + 700 * SAMPLE_CYCLES);
        push_end(32'd0);
        queue_frames(400);
        drain();

        write_mode(1'b0);
        cpu_cycles = 0;
        queue_frames(300);
        drain();

        // Rewrite the same mode: the block restarts anyway
        write_mode(1'b0);
        cpu_cycles = 0;
        queue_frames(100);
        drain();

        write_mode(1'b1);
        cpu_cycles = 0;
        queue_frames(300);
        drain();

        if (faults == 0)
            $display("** audio_sample_pacer: PASSED **");
        else
            $display("** audio_sample_pacer: FAILED **");
        $finish;
    end

endmodule
